### hdl/psksl_pkg.sv
// Package: types, constants and helper functions of the PSK slicer.
`default_nettype none

package psksl_pkg;

    // Default depth of the error energy window.
    localparam int HISTORY_DEPTH_DEF = 32;

    // Operand and product widths of the shared multiplier.
    localparam int A_W   = 34;
    localparam int B_W   = 19;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 1;

    // Error energy, Q2.30.
    localparam int ENERGY_W = 32;

    // Divider numerator and quotient widths.
    localparam int NUM_W = 40;
    localparam int Q_W   = 23;
    localparam int CNT_W = $clog2(Q_W + 1);

    // Ideal point amplitudes in Q1.15.
    localparam logic signed [9:0] AMP_AXIS = 10'sd328;
    localparam logic signed [9:0] AMP_DIAG = 10'sd232;

    // 8PSK metric weights and sector thresholds, scaled by 65536.
    localparam int W_SMALL = 25080;
    localparam int W_LARGE = 60547;
    localparam int TH_LOW  = 27146;
    localparam int TH_HIGH = 158218;

    // Epsilon added to the energy sum, Q2.30.
    localparam int EPS = 1074;

    // APB address width and register index of the modulation register.
    localparam int  PADDR_W        = 3;
    localparam logic REG_MODULATION = 1'b0;

    typedef enum logic [1:0] {
        MOD_BPSK = 2'd0,
        MOD_QPSK = 2'd1,
        MOD_8PSK = 2'd2
    } mod_t;

    typedef enum logic [1:0] {
        SEC_AXIS      = 2'd0,
        SEC_DIAG_LOW  = 2'd1,
        SEC_DIAG_HIGH = 2'd2,
        SEC_VERT      = 2'd3
    } sector_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_IR,
        ST_MUL_RI,
        ST_DI,
        ST_TH_HIGH,
        ST_SECTOR,
        ST_W_FIRST,
        ST_W_SECOND,
        ST_W_DIFF,
        ST_METRIC,
        ST_IDL_RC,
        ST_IDL_IC,
        ST_IDL_RI,
        ST_IDL_II,
        ST_IDL_DONE,
        ST_ERR_I,
        ST_ENG_A,
        ST_ENG_B,
        ST_WAIT
    } state_t;

    typedef enum logic [3:0] {
        MS_SR_CR,
        MS_SI_CI,
        MS_SI_CR,
        MS_SR_CI,
        MS_RA_TL,
        MS_RA_TH,
        MS_P1,
        MS_P2,
        MS_PR_CR,
        MS_PI_CI,
        MS_PR_CI,
        MS_PI_CR,
        MS_ER_ER,
        MS_EI_EI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    // Decision of one symbol: data value, ideal point, per-bit sign flips,
    // enabled soft bits and soft bit count.
    typedef struct packed {
        logic [2:0]        data;
        logic signed [9:0] pr;
        logic signed [9:0] pi;
        logic [2:0]        neg;
        logic [2:0]        en;
        logic [2:0]        cnt;
    } dec_t;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     ld_dr;
        logic     ld_di;
        logic     ld_low;
        logic     ld_sector;
        logic     ld_metric;
        logic     ld_ir;
        logic     ld_er;
        logic     ld_ii;
        logic     ld_ei;
        logic     ring_upd;
        logic     ld_out;
    } ctrl_t;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Q2.30 to Q1.15, rounding half up.
    function automatic logic signed [15:0] round_q15(input logic signed [25:0] p);
        logic signed [26:0] t;
        logic signed [26:0] q;
        t = 27'(p) + 27'sd16384;
        q = t >>> 15;
        return q[15:0];
    endfunction

    function automatic dec_t slice_decide(input logic [1:0] mode, input logic dr_neg,
                                          input logic dr_pos, input logic di_neg,
                                          input logic r_gt_i, input sector_t sec);
        dec_t       d;
        logic [2:0] base;
        logic [2:0] idx;
        d    = '0;
        base = 3'd0;
        idx  = 3'd0;
        case (mode)
            MOD_BPSK: begin
                d.cnt = 3'd1;
                d.en  = 3'b001;
                if (dr_pos) begin
                    d.data = 3'd0;
                    d.pr   = AMP_AXIS;
                end else begin
                    d.data = 3'd1;
                    d.pr   = -AMP_AXIS;
                end
            end
            MOD_QPSK: begin
                d.cnt = 3'd2;
                d.en  = 3'b011;
                if (r_gt_i) begin
                    if (!dr_neg) begin
                        d.data = 3'd0;
                        d.pr   = AMP_AXIS;
                    end else begin
                        d.data = 3'd3;
                        d.pr   = -AMP_AXIS;
                        d.neg  = 3'b011;
                    end
                end else begin
                    if (!di_neg) begin
                        d.data = 3'd1;
                        d.pi   = AMP_AXIS;
                        d.neg  = 3'b010;
                    end else begin
                        d.data = 3'd2;
                        d.pi   = -AMP_AXIS;
                        d.neg  = 3'b001;
                    end
                end
            end
            default: begin
                d.cnt = 3'd4;
                d.en  = 3'b111;
                case (sec)
                    SEC_AXIS: base = 3'd0;
                    SEC_VERT: base = 3'd2;
                    default:  base = 3'd1;
                endcase
                if (!dr_neg) begin
                    idx = di_neg ? 3'd0 - base : base;
                end else begin
                    idx = di_neg ? 3'd4 + base : 3'd4 - base;
                end
                case (idx)
                    3'd1: begin
                        d.data = 3'd0; d.neg = 3'b000; d.pr = AMP_DIAG;  d.pi = AMP_DIAG;
                    end
                    3'd2: begin
                        d.data = 3'd2; d.neg = 3'b010; d.pi = AMP_AXIS;
                    end
                    3'd3: begin
                        d.data = 3'd3; d.neg = 3'b110; d.pr = -AMP_DIAG; d.pi = AMP_DIAG;
                    end
                    3'd4: begin
                        d.data = 3'd7; d.neg = 3'b111; d.pr = -AMP_AXIS;
                    end
                    3'd5: begin
                        d.data = 3'd6; d.neg = 3'b011; d.pr = -AMP_DIAG; d.pi = -AMP_DIAG;
                    end
                    3'd6: begin
                        d.data = 3'd4; d.neg = 3'b001; d.pi = -AMP_AXIS;
                    end
                    3'd7: begin
                        d.data = 3'd5; d.neg = 3'b101; d.pr = AMP_DIAG;  d.pi = -AMP_DIAG;
                    end
                    default: begin
                        d.data = 3'd1; d.neg = 3'b100; d.pr = AMP_AXIS;
                    end
                endcase
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/psksl_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module psksl_mul
    import psksl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0]      p
);

    logic signed [P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= P_W'(a) * P_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### hdl/psksl_div.sv
// Restoring divider producing one saturating quotient bit per cycle.
`default_nettype none

module psksl_div
    import psksl_pkg::*;
#(
    parameter int DEN_W = ENERGY_W + $clog2(HISTORY_DEPTH_DEF) + 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [Q_W-1:0]        quot
);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   lo_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             sat;

    // A quotient of 2^23 or more saturates straight away.
    assign sat   = DEN_W'(num[NUM_W-1:Q_W]) >= den;
    assign trial = {rem_reg, lo_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        if (fits) begin
            rem_next = DEN_W'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= !sat;
            cnt_reg  <= CNT_W'(Q_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= DEN_W'(num[NUM_W-1:Q_W]);
            lo_reg  <= num[Q_W-1:0];
            q_reg   <= sat ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

### hdl/psksl_ring.sv
// Error energy window: ring memory, running sum and clearing pass.
`default_nettype none

module psksl_ring
    import psksl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int SUM_W         = ENERGY_W + $clog2(HISTORY_DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                upd,
    input  wire logic [ENERGY_W-1:0] energy,
    output logic                     busy,
    output logic [SUM_W-1:0]         sum
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [ENERGY_W-1:0] mem [HISTORY_DEPTH];
    logic [ENERGY_W-1:0] rd_reg;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                busy_reg;
    logic [SUM_W-1:0]    sum_reg;

    assign ptr_next = (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[ptr_reg] <= '0;
        end else if (upd) begin
            mem[ptr_reg] <= energy;
        end
        rd_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
            sum_reg  <= '0;
        end else if (busy_reg) begin
            ptr_reg <= ptr_next;
            if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
        end else if (upd) begin
            ptr_reg <= ptr_next;
            sum_reg <= sum_reg - SUM_W'(rd_reg) + SUM_W'(energy);
        end
    end

    assign busy = busy_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire

### hdl/psk_slicer_with_mse_soft_decision.sv
// Top level of the PSK slicer: sequencer, datapath and configuration port.
`default_nettype none

// Channel     Direction  Handshake           Contents
// s_ (input)  in         s_valid / s_ready   received symbol and scrambler symbol, Q1.15
// m_ (result) out        m_valid / m_ready   data symbol, ideal point, error, soft bits
// APB         in / out   psel/penable/pready modulation register at byte address 0
//
// The 23 quotient steps of the soft bit divider overlap the multiplier work, and a
// saturated soft bit skips the quotient steps. After reset the energy ring is cleared,
// one entry a cycle, and s_ready stays low meanwhile. A finished result waits in the
// output register; the next item can be taken in the cycle after, and is held at its end
// until the register is free.

module psk_slicer_with_mse_soft_decision
    import psksl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_symbol_re,
    input  wire logic signed [15:0] s_symbol_im,
    input  wire logic signed [15:0] s_scrambler_re,
    input  wire logic signed [15:0] s_scrambler_im,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_data_symbol,
    output logic signed [15:0]      m_ideal_re,
    output logic signed [15:0]      m_ideal_im,
    output logic signed [15:0]      m_error_re,
    output logic signed [15:0]      m_error_im,
    output logic signed [23:0]      m_soft_first,
    output logic signed [23:0]      m_soft_second,
    output logic signed [23:0]      m_soft_third,
    output logic signed [23:0]      m_soft_fourth,
    output logic [2:0]              m_soft_valid_count
);

    // The window sum grows by one bit for each doubling of the depth.
    localparam int SUM_W = ENERGY_W + $clog2(HISTORY_DEPTH);
    localparam int DEN_W = SUM_W + 1;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [1:0] mode_reg;

    // Captured item.
    logic signed [15:0] sr_reg, si_reg, cr_reg, ci_reg;

    // Shared multiplier and its accumulator.
    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] sum_ap, diff_ap;

    // Descrambled symbol, Q3.30, and its magnitudes.
    logic signed [32:0] dr_reg, di_reg;
    logic [32:0]        rabs, iabs;
    logic               r_gt_i;
    logic [48:0]        ia_shift;
    logic               ia_le_prod;

    logic    low_reg;
    sector_t sector_reg, sector_now;

    // Decision and metric.
    dec_t             dec_now, dec_reg;
    logic             mneg_reg, mneg_now;
    logic [NUM_W-1:0] num_now;
    logic [32:0]      qdiff;
    logic [ACC_W-1:0] macc;

    logic signed [15:0] ir_reg, ii_reg, er_reg, ei_reg;

    // Divider and energy ring.
    logic             div_busy;
    logic [Q_W-1:0]   quot;
    logic             ring_busy;
    logic [SUM_W-1:0] energy_sum;
    logic [ENERGY_W-1:0] energy;

    // Output register.
    logic               m_valid_reg;
    logic [2:0]         data_out_reg;
    logic signed [15:0] ir_out_reg, ii_out_reg, er_out_reg, ei_out_reg;
    logic signed [23:0] soft_reg [4];
    logic [2:0]         cnt_out_reg;
    logic signed [23:0] soft_mag;
    logic               out_free;

    // ---------------------------------------------------------------------
    // Configuration port. Only the low two bits of the written value are kept.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MOD_BPSK;
        end else if (psel && penable && pwrite && paddr[2] == REG_MODULATION) begin
            mode_reg <= pwdata[1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MODULATION) begin
            prdata = {30'd0, mode_reg};
        end else begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer. The multiplier product is registered, so each state consumes
    // the product issued by the one before.
    // ---------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE) && !ring_busy;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid && s_ready) state_next = ST_MUL_RR;
            ST_MUL_RR:   state_next = ST_MUL_II;
            ST_MUL_II:   state_next = ST_MUL_IR;
            ST_MUL_IR:   state_next = ST_MUL_RI;
            ST_MUL_RI:   state_next = ST_DI;
            ST_DI: begin
                // Values two and three both slice as 8PSK.
                if (mode_reg[1]) begin
                    state_next = ST_TH_HIGH;
                end else begin
                    state_next = ST_METRIC;
                end
            end
            ST_TH_HIGH:  state_next = ST_SECTOR;
            ST_SECTOR:   state_next = ST_W_FIRST;
            ST_W_FIRST:  state_next = ST_W_SECOND;
            ST_W_SECOND: state_next = ST_W_DIFF;
            ST_W_DIFF:   state_next = ST_METRIC;
            ST_METRIC:   state_next = ST_IDL_RC;
            ST_IDL_RC:   state_next = ST_IDL_IC;
            ST_IDL_IC:   state_next = ST_IDL_RI;
            ST_IDL_RI:   state_next = ST_IDL_II;
            ST_IDL_II:   state_next = ST_IDL_DONE;
            ST_IDL_DONE: state_next = ST_ERR_I;
            ST_ERR_I:    state_next = ST_ENG_A;
            ST_ENG_A:    state_next = ST_ENG_B;
            ST_ENG_B:    state_next = ST_WAIT;
            ST_WAIT:     if (!div_busy && out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl         = '0;
        ctrl.mul_sel = MS_SR_CR;
        ctrl.acc_op  = ACC_HOLD;
        unique case (state_reg)
            ST_MUL_RR: ctrl.mul_sel = MS_SR_CR;
            ST_MUL_II: begin
                ctrl.mul_sel = MS_SI_CI;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_MUL_IR: begin
                ctrl.mul_sel = MS_SI_CR;
                ctrl.ld_dr   = 1'b1;
            end
            ST_MUL_RI: begin
                ctrl.mul_sel = MS_SR_CI;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_DI: begin
                ctrl.mul_sel = MS_RA_TL;
                ctrl.ld_di   = 1'b1;
            end
            ST_TH_HIGH: begin
                ctrl.mul_sel = MS_RA_TH;
                ctrl.ld_low  = 1'b1;
            end
            ST_SECTOR:  ctrl.ld_sector = 1'b1;
            ST_W_FIRST: ctrl.mul_sel   = MS_P1;
            ST_W_SECOND: begin
                ctrl.mul_sel = MS_P2;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_W_DIFF:  ctrl.acc_op    = ACC_SUB;
            ST_METRIC:  ctrl.ld_metric = 1'b1;
            ST_IDL_RC:  ctrl.mul_sel   = MS_PR_CR;
            ST_IDL_IC: begin
                ctrl.mul_sel = MS_PI_CI;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_IDL_RI: begin
                ctrl.mul_sel = MS_PR_CI;
                ctrl.ld_ir   = 1'b1;
            end
            ST_IDL_II: begin
                ctrl.mul_sel = MS_PI_CR;
                ctrl.acc_op  = ACC_LOAD;
                ctrl.ld_er   = 1'b1;
            end
            ST_IDL_DONE: begin
                ctrl.mul_sel = MS_ER_ER;
                ctrl.ld_ii   = 1'b1;
            end
            ST_ERR_I: begin
                ctrl.acc_op = ACC_LOAD;
                ctrl.ld_ei  = 1'b1;
            end
            ST_ENG_A:  ctrl.mul_sel  = MS_EI_EI;
            ST_ENG_B:  ctrl.ring_upd = 1'b1;
            ST_WAIT:   ctrl.ld_out   = !div_busy && out_free;
            default: begin
                ctrl.mul_sel = MS_SR_CR;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sr_reg <= s_symbol_re;
            si_reg <= s_symbol_im;
            cr_reg <= s_scrambler_re;
            ci_reg <= s_scrambler_im;
        end
    end

    assign rabs     = dr_reg[32] ? 33'(-dr_reg) : 33'(dr_reg);
    assign iabs     = di_reg[32] ? 33'(-di_reg) : 33'(di_reg);
    assign r_gt_i   = rabs > iabs;
    assign ia_shift = {iabs, 16'd0};
    assign ia_le_prod = {4'd0, ia_shift} <= $unsigned(prod);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            MS_SR_CR: begin mul_a = A_W'(sr_reg); mul_b = B_W'(cr_reg); end
            MS_SI_CI: begin mul_a = A_W'(si_reg); mul_b = B_W'(ci_reg); end
            MS_SI_CR: begin mul_a = A_W'(si_reg); mul_b = B_W'(cr_reg); end
            MS_SR_CI: begin mul_a = A_W'(sr_reg); mul_b = B_W'(ci_reg); end
            MS_RA_TL: begin mul_a = {1'b0, rabs}; mul_b = B_W'(TH_LOW);  end
            MS_RA_TH: begin mul_a = {1'b0, rabs}; mul_b = B_W'(TH_HIGH); end
            MS_P1: begin
                case (sector_reg)
                    SEC_AXIS:      begin mul_a = {1'b0, rabs}; mul_b = B_W'(W_SMALL); end
                    SEC_DIAG_LOW:  begin mul_a = {1'b0, iabs}; mul_b = B_W'(W_LARGE); end
                    SEC_DIAG_HIGH: begin mul_a = {1'b0, rabs}; mul_b = B_W'(W_LARGE); end
                    default:       begin mul_a = {1'b0, iabs}; mul_b = B_W'(W_SMALL); end
                endcase
            end
            MS_P2: begin
                case (sector_reg)
                    SEC_AXIS:      begin mul_a = {1'b0, iabs}; mul_b = B_W'(W_LARGE); end
                    SEC_DIAG_LOW:  begin mul_a = {1'b0, rabs}; mul_b = B_W'(W_SMALL); end
                    SEC_DIAG_HIGH: begin mul_a = {1'b0, iabs}; mul_b = B_W'(W_SMALL); end
                    default:       begin mul_a = {1'b0, rabs}; mul_b = B_W'(W_LARGE); end
                endcase
            end
            MS_PR_CR: begin mul_a = A_W'(cr_reg); mul_b = B_W'(dec_reg.pr); end
            MS_PI_CI: begin mul_a = A_W'(ci_reg); mul_b = B_W'(dec_reg.pi); end
            MS_PR_CI: begin mul_a = A_W'(ci_reg); mul_b = B_W'(dec_reg.pr); end
            MS_PI_CR: begin mul_a = A_W'(cr_reg); mul_b = B_W'(dec_reg.pi); end
            MS_ER_ER: begin mul_a = A_W'(er_reg); mul_b = B_W'(er_reg); end
            MS_EI_EI: begin mul_a = A_W'(ei_reg); mul_b = B_W'(ei_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    psksl_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign sum_ap  = acc_reg + ACC_W'(prod);
    assign diff_ap = acc_reg - ACC_W'(prod);

    always_ff @(posedge aclk) begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod);
            ACC_SUB:  acc_reg <= diff_ap;
            default:  acc_reg <= acc_reg;
        endcase
        if (ctrl.ld_dr) begin
            dr_reg <= sum_ap[32:0];
        end
        if (ctrl.ld_di) begin
            di_reg <= diff_ap[32:0];
        end
        if (ctrl.ld_low) begin
            low_reg <= ia_le_prod;
        end
        if (ctrl.ld_sector) begin
            sector_reg <= sector_now;
        end
        if (ctrl.ld_metric) begin
            dec_reg  <= dec_now;
            mneg_reg <= mneg_now;
        end
        if (ctrl.ld_ir) begin
            ir_reg <= round_q15(diff_ap[25:0]);
        end
        if (ctrl.ld_er) begin
            er_reg <= sat16(17'(ir_reg) - 17'(sr_reg));
        end
        if (ctrl.ld_ii) begin
            ii_reg <= round_q15(sum_ap[25:0]);
        end
        if (ctrl.ld_ei) begin
            ei_reg <= sat16(17'(ii_reg) - 17'(si_reg));
        end
    end

    // Sector from the two threshold products; the comparisons use products,
    // so a zero symbol lands in the axis sector.
    always_comb begin
        if (low_reg) begin
            sector_now = SEC_AXIS;
        end else if (iabs <= rabs) begin
            sector_now = SEC_DIAG_LOW;
        end else if (ia_le_prod) begin
            sector_now = SEC_DIAG_HIGH;
        end else begin
            sector_now = SEC_VERT;
        end
    end

    assign dec_now = slice_decide(mode_reg, dr_reg[32], !dr_reg[32] && (dr_reg != '0),
                                  di_reg[32], r_gt_i, sector_reg);

    // Divider numerator: metric magnitude in Q2.46, times 256, over 65536.
    assign qdiff = r_gt_i ? rabs - iabs : iabs - rabs;
    assign macc  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb begin
        case (mode_reg)
            MOD_BPSK: begin
                num_now  = {rabs[31:0], 8'd0};
                mneg_now = dr_reg[32];
            end
            MOD_QPSK: begin
                num_now  = {qdiff[31:0], 8'd0};
                mneg_now = 1'b0;
            end
            default: begin
                num_now  = macc[NUM_W+7:8];
                mneg_now = acc_reg[ACC_W-1];
            end
        endcase
    end

    psksl_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.ld_metric),
        .num     (num_now),
        .den     (DEN_W'(energy_sum) + DEN_W'(EPS)),
        .busy    (div_busy),
        .quot    (quot)
    );

    // The energy enters the window only after the divider has taken the sum.
    assign energy = sum_ap[ENERGY_W-1:0];

    psksl_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_W         (SUM_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (ctrl.ring_upd),
        .energy  (energy),
        .busy    (ring_busy),
        .sum     (energy_sum)
    );

    // ---------------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------------
    assign soft_mag = {1'b0, quot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_out) begin
            data_out_reg <= dec_reg.data;
            ir_out_reg   <= ir_reg;
            ii_out_reg   <= ii_reg;
            er_out_reg   <= er_reg;
            ei_out_reg   <= ei_reg;
            cnt_out_reg  <= dec_reg.cnt;
            for (int k = 0; k < 3; k++) begin
                if (!dec_reg.en[k]) begin
                    soft_reg[k] <= '0;
                end else if (dec_reg.neg[k] ^ mneg_reg) begin
                    soft_reg[k] <= -soft_mag;
                end else begin
                    soft_reg[k] <= soft_mag;
                end
            end
            soft_reg[3] <= '0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data_symbol      = data_out_reg;
    assign m_ideal_re         = ir_out_reg;
    assign m_ideal_im         = ii_out_reg;
    assign m_error_re         = er_out_reg;
    assign m_error_im         = ei_out_reg;
    assign m_soft_first       = soft_reg[0];
    assign m_soft_second      = soft_reg[1];
    assign m_soft_third       = soft_reg[2];
    assign m_soft_fourth      = soft_reg[3];
    assign m_soft_valid_count = cnt_out_reg;

endmodule

`default_nettype wire

### tb/sv/psk_slicer_checker.sv
// Checker for the PSK slicer: predicts each result from accepted items and compares.
`timescale 1ns / 100ps

module psk_slicer_checker
    import psksl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic signed [15:0] s_symbol_re,
    input  wire logic signed [15:0] s_symbol_im,
    input  wire logic signed [15:0] s_scrambler_re,
    input  wire logic signed [15:0] s_scrambler_im,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [2:0]         m_data_symbol,
    input  wire logic signed [15:0] m_ideal_re,
    input  wire logic signed [15:0] m_ideal_im,
    input  wire logic signed [15:0] m_error_re,
    input  wire logic signed [15:0] m_error_im,
    input  wire logic signed [23:0] m_soft_first,
    input  wire logic signed [23:0] m_soft_second,
    input  wire logic signed [23:0] m_soft_third,
    input  wire logic signed [23:0] m_soft_fourth,
    input  wire logic [2:0]         m_soft_valid_count,
    output int                      fail_count,
    output int                      pending,
    output int                      symbols_checked
);

    typedef struct packed {
        logic [2:0]         data;
        logic signed [15:0] ir;
        logic signed [15:0] ii;
        logic signed [15:0] er;
        logic signed [15:0] ei;
        logic signed [23:0] s0;
        logic signed [23:0] s1;
        logic signed [23:0] s2;
        logic signed [23:0] s3;
        logic [2:0]         cnt;
    } decision_t;

    decision_t    decisions_due[$];
    logic [31:0]  err_energy[HISTORY_DEPTH];
    logic [36:0]  err_sum;
    int           slot;
    logic [1:0]   mode;

    function automatic longint clip16(input longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint to_q15(input longint p);
        longint t;
        t = p + 16384;
        return clip16(t >>> 15);
    endfunction

    function automatic longint soft_value(input longint m46, input longint den);
        longint mag;
        longint q;
        mag = m46 < 0 ? -m46 : m46;
        q = (mag * 256) / den;
        if (q > 8388607) q = 8388607;
        return m46 < 0 ? -q : q;
    endfunction

    function automatic decision_t slice_symbol(input longint sr, input longint si,
                                               input longint cr, input longint ci);
        decision_t d;
        longint dr, di, ra, ia, den, s, m, pr, pi, ir, ii, er, ei;
        longint sf[4];
        int angle, g0, g1, g2;
        dr = sr * cr + si * ci;
        di = si * cr - sr * ci;
        ra = dr < 0 ? -dr : dr;
        ia = di < 0 ? -di : di;
        den = (longint'(err_sum) + EPS) * 65536;
        sf = '{0, 0, 0, 0};
        pr = 0; pi = 0;
        d = '0;
        if (mode == MOD_BPSK) begin
            d.cnt = 1;
            sf[0] = soft_value(dr * 65536, den);
            if (dr > 0) begin d.data = 0; pr = 328; end
            else begin d.data = 1; pr = -328; end
        end else if (mode == MOD_QPSK) begin
            d.cnt = 2;
            if (ra > ia) begin
                s = soft_value((ra - ia) * 65536, den);
                if (dr >= 0) begin d.data = 0; sf[0] = s; sf[1] = s; pr = 328; end
                else begin d.data = 3; sf[0] = -s; sf[1] = -s; pr = -328; end
            end else begin
                s = soft_value((ia - ra) * 65536, den);
                if (di >= 0) begin d.data = 1; sf[0] = s; sf[1] = -s; pi = 328; end
                else begin d.data = 2; sf[0] = -s; sf[1] = s; pi = -328; end
            end
        end else begin
            d.cnt = 4;
            // Sector tests by products so that a zero symbol lands on the axis.
            if (ia * 65536 <= ra * TH_LOW) begin
                m = W_SMALL * ra - W_LARGE * ia; angle = 0;
            end else if (ia <= ra) begin
                m = W_LARGE * ia - W_SMALL * ra; angle = 45;
            end else if (ia * 65536 <= ra * TH_HIGH) begin
                m = W_LARGE * ra - W_SMALL * ia; angle = 45;
            end else begin
                m = W_SMALL * ia - W_LARGE * ra; angle = 90;
            end
            s = soft_value(m, den);
            if (dr >= 0) begin
                if (di < 0) angle = 360 - angle;
            end else begin
                angle = di >= 0 ? 180 - angle : 180 + angle;
            end
            case (angle)
                45:  begin d.data = 0; g0 = 1;  g1 = 1;  g2 = 1;  pr = 232;  pi = 232;  end
                90:  begin d.data = 2; g0 = 1;  g1 = -1; g2 = 1;  pi = 328;  end
                135: begin d.data = 3; g0 = 1;  g1 = -1; g2 = -1; pr = -232; pi = 232;  end
                180: begin d.data = 7; g0 = -1; g1 = -1; g2 = -1; pr = -328; end
                225: begin d.data = 6; g0 = -1; g1 = -1; g2 = 1;  pr = -232; pi = -232; end
                270: begin d.data = 4; g0 = -1; g1 = 1;  g2 = 1;  pi = -328; end
                315: begin d.data = 5; g0 = -1; g1 = 1;  g2 = -1; pr = 232;  pi = -232; end
                default: begin d.data = 1; g0 = 1; g1 = 1; g2 = -1; pr = 328; end
            endcase
            sf[0] = g0 * s; sf[1] = g1 * s; sf[2] = g2 * s;
        end
        ir = to_q15(pr * cr - pi * ci);
        ii = to_q15(pr * ci + pi * cr);
        er = clip16(ir - sr);
        ei = clip16(ii - si);
        d.ir = ir; d.ii = ii; d.er = er; d.ei = ei;
        d.s0 = sf[0]; d.s1 = sf[1]; d.s2 = sf[2]; d.s3 = sf[3];
        // The window is updated after the soft bits have used the old sum.
        err_sum = err_sum - err_energy[slot] + 37'(er * er + ei * ei);
        err_energy[slot] = 32'(er * er + ei * ei);
        slot = (slot + 1) % HISTORY_DEPTH;
        return d;
    endfunction

    decision_t got;
    decision_t want;
    assign got = '{m_data_symbol, m_ideal_re, m_ideal_im, m_error_re, m_error_im,
                   m_soft_first, m_soft_second, m_soft_third, m_soft_fourth,
                   m_soft_valid_count};
    assign pending = decisions_due.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) err_energy[i] = '0;
            err_sum = '0;
            slot = 0;
            mode = MOD_BPSK;
            fail_count <= 0;
            symbols_checked <= 0;
            decisions_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MODULATION)
                mode = pwdata[1:0];
            if (s_valid && s_ready)
                decisions_due.push_back(slice_symbol(s_symbol_re, s_symbol_im,
                                                     s_scrambler_re, s_scrambler_im));
            if (m_valid && m_ready) begin
                symbols_checked <= symbols_checked + 1;
                if (decisions_due.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result item %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = decisions_due.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch at item %0d: expected %p, got %p",
                                     symbols_checked, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_psk_slicer_with_mse_soft_decision.sv
// Testbench top for the PSK slicer: stimulus, register phases and verdict.
`timescale 1ns / 100ps

module tb_psk_slicer_with_mse_soft_decision;
    import psksl_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_symbol_re = '0;
    logic signed [15:0] s_symbol_im = '0;
    logic signed [15:0] s_scrambler_re = '0;
    logic signed [15:0] s_scrambler_im = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_data_symbol;
    logic signed [15:0] m_ideal_re, m_ideal_im, m_error_re, m_error_im;
    logic signed [23:0] m_soft_first, m_soft_second, m_soft_third, m_soft_fourth;
    logic [2:0]         m_soft_valid_count;
    int                 fail_count, pending, symbols_checked;

    // Idling controls: a quiet stretch switches idling off on both sides, and a
    // hold-off keeps the result side stalled so that the block backs up.
    bit   quiet = 1'b0;
    bit   hold_off = 1'b0;
    int   idle_cycles = 0;
    int   items_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    psk_slicer_with_mse_soft_decision i_dut (.*);

    psk_slicer_checker i_checker (.*);

    // The receiver stalls at random about 12 percent of the time unless held off or quiet.
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 12);
        end
    end

    // Watchdog: counts cycles in which no item moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_modulation(input logic [31:0] value);
        // Setup cycle, then the access cycle at which the register takes the value.
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offers one item and holds it until it is taken; a random gap comes first,
    // during which nothing is offered.
    task automatic send_symbol(input logic [15:0] sr, input logic [15:0] si,
                               input logic [15:0] cr, input logic [15:0] ci);
        while (!quiet && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_symbol_re <= sr; s_symbol_im <= si;
        s_scrambler_re <= cr; s_scrambler_im <= ci;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
    endtask

    // Random values lean on full scale, small amplitudes and unit scrambler points.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scrambler();
        case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8001;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        drop_valid();
        while (pending != 0) @(posedge aclk);
        // The next item may still be in flight behind the last result.
        repeat (60) @(posedge aclk);
    endtask

    task automatic directed_set();
        send_symbol(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_symbol(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
        send_symbol(16'h8000, 16'h0000, 16'h7FFF, 16'h0000);
        send_symbol(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_symbol(16'h0000, 16'h8000, 16'h7FFF, 16'h0000);
        send_symbol(16'h4000, 16'h4000, 16'h7FFF, 16'h0000);
        send_symbol(16'hC000, 16'h4000, 16'h7FFF, 16'h0000);
        send_symbol(16'hC000, 16'hC000, 16'h7FFF, 16'h0000);
        send_symbol(16'h4000, 16'hC000, 16'h7FFF, 16'h0000);
        send_symbol(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_symbol(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_symbol(16'h1234, 16'h0123, 16'h0000, 16'h0000);
    endtask

    initial begin
        logic [31:0] modes[6];
        modes = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFE, 32'd1};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed symbols in every slicing mode, including the zero symbol.
        for (int p = 0; p < 4; p++) begin
            write_modulation(modes[p]);
            directed_set();
            wait_drained();
        end

        // Random phases, one of them with idling off and one with a long stall.
        for (int p = 0; p < 6; p++) begin
            write_modulation(modes[p]);
            quiet = (p == 2);
            for (int n = 0; n < 110; n++) begin
                if (p == 4 && n == 20) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (400) @(posedge aclk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_symbol(pick_sample(), pick_sample(), pick_scrambler(),
                            pick_scrambler());
            end
            quiet = 1'b0;
            wait_drained();
        end

        $display("Sent %0d symbols through BPSK, QPSK, 8PSK and the fourth mode value,",
                 items_sent);
        $display("and checked %0d results against the prediction.", symbols_checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
